/* design/rcbd_pkg.sv */
// Package for the robot command byte decoder: selector codes, direction codes,
// result beat layout and the constant-multiply scaling functions.
// No dependencies.
`timescale 1ns / 1ps

package rcbd_pkg;

    localparam logic [7:0] SEL_BUZZER    = 8'd201;
    localparam logic [7:0] SEL_MOTOR1    = 8'd202;
    localparam logic [7:0] SEL_MOTOR2    = 8'd203;
    localparam logic [7:0] SEL_DUTY0     = 8'd204;
    localparam logic [7:0] SEL_DUTY3     = 8'd207;
    localparam logic [7:0] SEL_SERVO0    = 8'd208;
    localparam logic [7:0] SEL_SERVO3    = 8'd211;
    localparam logic [7:0] SEL_SERVO_OFF = 8'd212;
    localparam logic [7:0] SEL_ALL_STOP  = 8'd213;
    localparam logic [7:0] CONFIRM_VALUE = 8'd99;
    localparam logic [7:0] MOTOR_MID     = 8'd100;
    localparam logic [7:0] DUTY_MAX      = 8'd255;
    localparam logic [7:0] ANGLE_MAX     = 8'd180;

    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    // floor(v*235/100) = (v * 235 * 5243) >> 19 for v < 256
    localparam logic [28:0] MOTOR_RECIP = 29'd1232105;
    // floor(v*255/100) = (v * 255 * 5243) >> 19
    localparam logic [28:0] PWM_RECIP   = 29'd1336965;
    // floor(v*18/10) = (v * 9 * 52429) >> 18
    localparam logic [28:0] ANGLE_RECIP = 29'd471861;

    // Result beat, last field in the lowest bits
    typedef struct packed {
        logic [6:0] pad;
        logic [3:0] servo_mode_mask;
        logic [7:0] chan_d_level;
        logic [7:0] chan_c_level;
        logic [7:0] chan_b_level;
        logic [7:0] chan_a_level;
        logic [7:0] motor1_duty;
        logic [1:0] motor2_dir;
        logic [1:0] motor1_dir;
        logic       buzzer_on;
    } result_t;

    function automatic logic [1:0] motor_dir(input logic [7:0] v);
        return (v > MOTOR_MID) ? DIR_REV : DIR_FWD;
    endfunction

    function automatic logic [7:0] motor_duty(input logic [7:0] v);
        logic [7:0]  mag;
        logic [28:0] prod;
        logic [9:0]  q;
        mag  = (v > MOTOR_MID) ? v - MOTOR_MID : v;
        prod = {21'd0, mag} * MOTOR_RECIP;
        q    = prod[28:19];
        return (q > {2'd0, DUTY_MAX}) ? DUTY_MAX : q[7:0];
    endfunction

    function automatic logic [7:0] pwm_duty(input logic [7:0] v);
        logic [28:0] prod;
        logic [9:0]  q;
        prod = {21'd0, v} * PWM_RECIP;
        q    = prod[28:19];
        return (q > {2'd0, DUTY_MAX}) ? DUTY_MAX : q[7:0];
    endfunction

    function automatic logic [7:0] servo_angle(input logic [7:0] v);
        logic [28:0] prod;
        logic [10:0] q;
        prod = {21'd0, v} * ANGLE_RECIP;
        q    = prod[28:18];
        return (q > {3'd0, ANGLE_MAX}) ? ANGLE_MAX : q[7:0];
    endfunction

endpackage

/* design/robot_command_byte_decoder.sv */
// Robot command byte decoder top level: selector/value decode, drive state and
// the registered result beat. Depends on rcbd_pkg.
// The result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; the single result register is refilled in the
// same cycle it is drained, so s_tready follows m_tready when a result waits.
// Reset (aresetn low, synchronous): all drive state, the selector and m_tvalid clear.
`timescale 1ns / 1ps

module robot_command_byte_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] buzzer_on, [2:1] motor1_dir, [4:3] motor2_dir, [12:5] motor1_duty,
    // [20:13] chan_a_level, [28:21] chan_b_level, [36:29] chan_c_level,
    // [44:37] chan_d_level, [48:45] servo_mode_mask, [55:49] zero
    output logic [55:0] m_tdata
);

    logic [7:0] last_byte_reg,  last_byte_next;
    logic       buzzer_reg,     buzzer_next;
    logic [1:0] motor1_dir_reg, motor1_dir_next;
    logic [1:0] motor2_dir_reg, motor2_dir_next;
    logic [7:0] motor1_duty_reg, motor1_duty_next;
    logic [7:0] chan_duty_reg  [4];
    logic [7:0] chan_duty_next [4];
    logic [7:0] chan_angle_reg [4];
    logic [7:0] chan_angle_next[4];
    logic [3:0] servo_mode_reg, servo_mode_next;

    rcbd_pkg::result_t result_reg, result_next;
    logic              m_tvalid_reg;

    logic       s_accept;
    logic [7:0] v;
    logic [1:0] idx;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign v        = s_tdata;
    assign idx      = last_byte_reg[1:0];

    always_comb begin
        last_byte_next   = v;
        buzzer_next      = buzzer_reg;
        motor1_dir_next  = motor1_dir_reg;
        motor2_dir_next  = motor2_dir_reg;
        motor1_duty_next = motor1_duty_reg;
        chan_duty_next   = chan_duty_reg;
        chan_angle_next  = chan_angle_reg;
        servo_mode_next  = servo_mode_reg;

        case (last_byte_reg) inside
            rcbd_pkg::SEL_BUZZER: begin
                buzzer_next = (v != 8'd0);
            end
            rcbd_pkg::SEL_MOTOR1: begin
                motor1_dir_next  = rcbd_pkg::motor_dir(v);
                motor1_duty_next = rcbd_pkg::motor_duty(v);
            end
            rcbd_pkg::SEL_MOTOR2: begin
                // motor 2 duty shares channel D
                motor2_dir_next   = rcbd_pkg::motor_dir(v);
                chan_duty_next[3] = rcbd_pkg::motor_duty(v);
            end
            [rcbd_pkg::SEL_DUTY0:rcbd_pkg::SEL_DUTY3]: begin
                chan_duty_next[idx] = rcbd_pkg::pwm_duty(v);
            end
            [rcbd_pkg::SEL_SERVO0:rcbd_pkg::SEL_SERVO3]: begin
                servo_mode_next[idx] = 1'b1;
                chan_angle_next[idx] = rcbd_pkg::servo_angle(v);
            end
            rcbd_pkg::SEL_SERVO_OFF: begin
                if (v == rcbd_pkg::CONFIRM_VALUE) begin
                    servo_mode_next = 4'd0;
                end
            end
            rcbd_pkg::SEL_ALL_STOP: begin
                // release servos A and B, zero motor 1 duty and all four channel duties
                if (v == rcbd_pkg::CONFIRM_VALUE) begin
                    servo_mode_next[1:0] = 2'd0;
                    motor1_duty_next     = 8'd0;
                    for (int i = 0; i < 4; i++) begin
                        chan_duty_next[i] = 8'd0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result_next                 = '0;
        result_next.buzzer_on       = buzzer_next;
        result_next.motor1_dir      = motor1_dir_next;
        result_next.motor2_dir      = motor2_dir_next;
        result_next.motor1_duty     = motor1_duty_next;
        result_next.chan_a_level    = servo_mode_next[0] ? chan_angle_next[0] : chan_duty_next[0];
        result_next.chan_b_level    = servo_mode_next[1] ? chan_angle_next[1] : chan_duty_next[1];
        result_next.chan_c_level    = servo_mode_next[2] ? chan_angle_next[2] : chan_duty_next[2];
        result_next.chan_d_level    = servo_mode_next[3] ? chan_angle_next[3] : chan_duty_next[3];
        result_next.servo_mode_mask = servo_mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_byte_reg   <= 8'd0;
            buzzer_reg      <= 1'b0;
            motor1_dir_reg  <= 2'd0;
            motor2_dir_reg  <= 2'd0;
            motor1_duty_reg <= 8'd0;
            servo_mode_reg  <= 4'd0;
            m_tvalid_reg    <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                chan_duty_reg[i]  <= 8'd0;
                chan_angle_reg[i] <= 8'd0;
            end
        end else begin
            if (s_accept) begin
                last_byte_reg   <= last_byte_next;
                buzzer_reg      <= buzzer_next;
                motor1_dir_reg  <= motor1_dir_next;
                motor2_dir_reg  <= motor2_dir_next;
                motor1_duty_reg <= motor1_duty_next;
                servo_mode_reg  <= servo_mode_next;
                chan_duty_reg   <= chan_duty_next;
                chan_angle_reg  <= chan_angle_next;
                m_tvalid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = result_reg;

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid_reg |-> s_tready)
        else $error("input stalled with an empty result register");

    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && result_reg.servo_mode_mask[0] |->
            result_reg.chan_a_level <= rcbd_pkg::ANGLE_MAX)
        else $error("servo angle on channel A above limit");

    a_motor1_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> result_reg.motor1_dir != 2'd3)
        else $error("motor 1 driven both ways");

    a_mask_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !$past(s_accept) && $past(aresetn) |->
            result_reg.servo_mode_mask == servo_mode_reg)
        else $error("result servo mask out of step with state");

endmodule
